[src/ccs_pkg.sv]
package ccs_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    MODE_CODE   = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_BLOCK  = 2'd2,
    MODE_STRING = 2'd3
  } mode_t;

  // One result item as it sits in the output queue.
  typedef struct packed {
    logic [7:0] kept_byte;
    logic       has_byte;
    logic       stream_done;
  } result_t;

  // Results produced by one accepted input beat, zero to two of them.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    d0;
    result_t    d1;
  } push_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] prev;
    logic [7:0] emit;
    logic       valid;
    logic       skip;
  } scan_res_t;

  // Handles one character with optional lookahead and returns the new
  // mode, the last emitted byte and whether a byte goes out.
  function automatic scan_res_t scan_byte(mode_t mode, logic [7:0] prev, logic [7:0] c,
                                          logic has_la, logic [7:0] la);
    scan_res_t  r;
    logic [7:0] ch;
    r.mode  = mode;
    r.prev  = prev;
    r.emit  = 8'h00;
    r.valid = 1'b0;
    r.skip  = 1'b0;
    ch      = c;
    case (mode)
      MODE_CODE, MODE_STRING: begin
        if (mode == MODE_CODE) begin
          if (c == CH_SLASH && has_la && la == CH_SLASH) begin
            r.mode = MODE_LINE;
          end else if (c == CH_SLASH && has_la && la == CH_STAR) begin
            r.mode = MODE_BLOCK;
          end else if (c == CH_QUOTE) begin
            r.mode = MODE_STRING;
          end
          if (c == CH_NL || c == CH_TAB) begin
            ch = CH_SPACE;
          end
        end else if (c == CH_QUOTE) begin
          r.mode = MODE_CODE;
        end
        if (r.mode == MODE_CODE || r.mode == MODE_STRING) begin
          if (!(prev == CH_SPACE && ch == CH_SPACE)) begin
            r.prev  = ch;
            r.emit  = ch;
            r.valid = 1'b1;
          end
        end
      end
      MODE_LINE: begin
        if (c == CH_NL) begin
          r.mode = MODE_CODE;
        end
      end
      MODE_BLOCK: begin
        // The opening star is tested again here, so the slash that follows it closes.
        if (c == CH_STAR && has_la && la == CH_SLASH) begin
          r.mode = MODE_CODE;
          r.skip = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

[src/ccs_scanner.sv]
module ccs_scanner
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output push_t      push
);

  mode_t      scan_mode, scan_mode_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic [7:0] prev_emitted, prev_emitted_next;

  scan_res_t  r1, r2;
  mode_t      mode1;
  logic [7:0] prev1;
  logic       emit1, emit2, skip;

  always_comb begin
    r1 = scan_byte(scan_mode, prev_emitted, held_byte, 1'b1, text_byte);
    if (held_valid) begin
      mode1 = r1.mode;
      prev1 = r1.prev;
      emit1 = r1.valid;
      skip  = r1.skip;
    end else begin
      mode1 = scan_mode;
      prev1 = prev_emitted;
      emit1 = 1'b0;
      skip  = 1'b0;
    end

    // The final byte has no lookahead, so it can neither open nor close a comment.
    r2    = scan_byte(mode1, prev1, text_byte, 1'b0, 8'h00);
    emit2 = !skip && end_of_text && r2.valid;

    scan_mode_next    = mode1;
    prev_emitted_next = prev1;
    held_byte_next    = held_byte;
    held_valid_next   = 1'b0;
    if (!skip && !end_of_text) begin
      held_byte_next  = text_byte;
      held_valid_next = 1'b1;
    end else if (!skip && end_of_text) begin
      scan_mode_next    = r2.mode;
      prev_emitted_next = r2.prev;
    end
    if (end_of_text) begin
      scan_mode_next    = MODE_CODE;
      prev_emitted_next = 8'h00;
      held_byte_next    = 8'h00;
      held_valid_next   = 1'b0;
    end

    push.d0 = '0;
    push.d1 = '0;
    if (emit1 && emit2) begin
      push.cnt = 2'd2;
      push.d0  = '{kept_byte: r1.emit, has_byte: 1'b1, stream_done: 1'b0};
      push.d1  = '{kept_byte: r2.emit, has_byte: 1'b1, stream_done: 1'b1};
    end else if (emit1) begin
      push.cnt = 2'd1;
      push.d0  = '{kept_byte: r1.emit, has_byte: 1'b1, stream_done: end_of_text};
    end else if (emit2) begin
      push.cnt = 2'd1;
      push.d0  = '{kept_byte: r2.emit, has_byte: 1'b1, stream_done: 1'b1};
    end else if (end_of_text) begin
      push.cnt = 2'd1;
      push.d0  = '{kept_byte: 8'h00, has_byte: 1'b0, stream_done: 1'b1};
    end else begin
      push.cnt = 2'd0;
    end
    if (!in_fire) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode    <= MODE_CODE;
      held_byte    <= 8'h00;
      held_valid   <= 1'b0;
      prev_emitted <= 8'h00;
    end else if (in_fire) begin
      scan_mode    <= scan_mode_next;
      held_byte    <= held_byte_next;
      held_valid   <= held_valid_next;
      prev_emitted <= prev_emitted_next;
    end
  end

endmodule

[src/ccs_result_fifo.sv]
module ccs_result_fifo
  import ccs_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t        mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr, wr_ptr1, wr_ptr2, rd_ptr1;
  logic [CW-1:0]  count;
  logic           pop;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    logic [PW-1:0] q;
    if (p == PW'(DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + PW'(1);
    end
    return q;
  endfunction

  always_comb begin
    wr_ptr1   = ptr_inc(wr_ptr);
    wr_ptr2   = ptr_inc(wr_ptr1);
    rd_ptr1   = ptr_inc(rd_ptr);
    // Room for two results keeps the input side free of any dependence on out_ready.
    in_ready  = (count <= CW'(DEPTH - 2));
    out_valid = (count != '0);
    out_data  = mem[rd_ptr];
    pop       = out_valid && out_ready;
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.d0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr1] <= push.d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push.cnt)
        2'd1:    wr_ptr <= wr_ptr1;
        2'd2:    wr_ptr <= wr_ptr2;
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) begin
        rd_ptr <= rd_ptr1;
      end
      count <= count + CW'(push.cnt) - CW'(pop);
    end
  end

endmodule

[src/c_comment_stripper_unit.sv]
// C comment stripper. Raw source bytes enter on the s_ side, one beat per
// cycle, with s_tlast on the final byte of a text. One byte is held back as
// lookahead, so the result for a byte leaves when the next byte arrives;
// line and block comments are dropped, newline and tab outside strings turn
// into a space, and runs of spaces collapse to one. Each input beat yields
// at most one result, except the final one, which can yield two; a text that
// ends with nothing to emit gives a bare end beat with m_tuser low and
// m_tdata zero. m_tlast marks the last result of a text, after which the
// block starts the next text from its reset state. Throughput is one byte
// per cycle while m_tready is high: the scan logic is a single pass between
// the state registers and a result queue of FIFO_DEPTH entries, and s_tready
// is low only while the queue has fewer than two free entries, which happens
// only when m_tready is held low.
module c_comment_stripper_unit
  import ccs_pkg::*;
#(
  parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] kept_byte
  output logic       m_tuser,   // [0] has_byte
  output logic       m_tlast    // stream_done
);

  push_t   push;
  result_t head;
  logic    in_fire;

  assign in_fire = s_tvalid && s_tready;

  ccs_scanner u_scanner (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .text_byte   (s_tdata),
    .end_of_text (s_tlast),
    .push        (push)
  );

  ccs_result_fifo #(
    .DEPTH (FIFO_DEPTH_P)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (head)
  );

  assign m_tdata = head.kept_byte;
  assign m_tuser = head.has_byte;
  assign m_tlast = head.stream_done;

  // A bare end beat always closes the text.
  a_bare_is_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("bare end beat without stream_done");

  a_bare_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == 8'h00))
    else $error("bare end beat carries a nonzero byte");

  // The final byte of a text always produces at least one result.
  a_last_yields: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("final input beat produced no result");

endmodule
